### hdl/bfdp_pkg.sv
// ----------------------------------------------------------------------------
// bfdp_pkg
// Shared types, codes and sizes for the bounded FIFO with drop policy.
// ----------------------------------------------------------------------------
package bfdp_pkg;

  // Storage depth of the record memory.
  localparam int DEPTH = 64;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int VALUE_W = 32;
  localparam int ID_W    = 16;
  localparam int REC_W   = VALUE_W + ID_W;
  localparam int OCC_W   = 7;
  localparam int TOT_W   = 32;
  localparam int CFG_W   = 7;
  localparam int CFGI_W  = 1;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_MODE     = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_CAPACITY = 1'b1;

  // Capacity after reset.
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  // Request from the controller to the record memory.
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [REC_W-1:0] wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

  // Result of one item, apart from the popped record itself.
  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic             pop_ok;
    logic [OCC_W-1:0] occupancy;
    logic [TOT_W-1:0] dropped;
    logic [TOT_W-1:0] received;
    logic [TOT_W-1:0] released;
    logic [OCC_W-1:0] peak;
  } res_t;

endpackage

### hdl/bounded_fifo_with_drop_policy_top.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_drop_policy_top
// Bounded FIFO of sensor records with drop-newest or drop-oldest policy.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Ports
//  input     start & !busy          in_opcode, in_sensor_value, in_sensor_id
//  result    out_valid, one cycle   out_status .. out_peak_occupancy
//  config    cfg_we                 cfg_index, cfg_wdata
//
// One item is taken every cycle; busy stays low.
// The result appears in the cycle after the item; the record memory, whose
// read data is registered, returns a popped record together with it.
// Reset is synchronous and clears pointers, counts and configuration; the
// record memory needs no clearing, as only written entries are read.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module bounded_fifo_with_drop_policy_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_opcode,
  input  logic signed [bfdp_pkg::VALUE_W-1:0] in_sensor_value,
  input  logic [bfdp_pkg::ID_W-1:0]         in_sensor_id,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [bfdp_pkg::VALUE_W-1:0] out_value,
  output logic [bfdp_pkg::ID_W-1:0]         out_id,
  output logic [bfdp_pkg::OCC_W-1:0]        out_occupancy,
  output logic [bfdp_pkg::TOT_W-1:0]        out_dropped_count,
  output logic [bfdp_pkg::TOT_W-1:0]        out_received_count,
  output logic [bfdp_pkg::TOT_W-1:0]        out_released_count,
  output logic [bfdp_pkg::OCC_W-1:0]        out_peak_occupancy,
  input  logic                              cfg_we,
  input  logic [bfdp_pkg::CFGI_W-1:0]       cfg_index,
  input  logic [bfdp_pkg::CFG_W-1:0]        cfg_wdata
);

  logic                           accept;
  logic [bfdp_pkg::REC_W-1:0]     record;
  logic [bfdp_pkg::REC_W-1:0]     rd_rec;
  bfdp_pkg::ram_req_t             ram_req;
  bfdp_pkg::res_t                 res;

  // Every cycle can take an item.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign record = {in_sensor_value, in_sensor_id};

  // Queue controller.
  bfdp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_opcode),
    .record    (record),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ram_req   (ram_req),
    .res       (res)
  );

  // Record memory.
  bfdp_ram #(
    .WIDTH (bfdp_pkg::REC_W),
    .DEPTH (bfdp_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .re      (ram_req.re),
    .raddr   (ram_req.raddr),
    .rdata_r (rd_rec)
  );

  // Result item; the record fields are zero unless a pop succeeded.
  assign out_valid          = res.valid;
  assign out_status         = res.status;
  assign out_value          = res.pop_ok ? rd_rec[bfdp_pkg::REC_W-1:bfdp_pkg::ID_W] : '0;
  assign out_id             = res.pop_ok ? rd_rec[bfdp_pkg::ID_W-1:0] : '0;
  assign out_occupancy      = res.occupancy;
  assign out_dropped_count  = res.dropped;
  assign out_received_count = res.received;
  assign out_released_count = res.released;
  assign out_peak_occupancy = res.peak;

endmodule

### hdl/bfdp_ram.sv
// ----------------------------------------------------------------------------
// bfdp_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bfdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### hdl/bfdp_ctrl.sv
// ----------------------------------------------------------------------------
// bfdp_ctrl
// Queue controller: pointers, occupancy, policy, statistics and config regs.
// ----------------------------------------------------------------------------
module bfdp_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic                             opcode,
  input  logic [bfdp_pkg::REC_W-1:0]       record,
  input  logic                             cfg_we,
  input  logic [bfdp_pkg::CFGI_W-1:0]      cfg_index,
  input  logic [bfdp_pkg::CFG_W-1:0]       cfg_wdata,
  output bfdp_pkg::ram_req_t               ram_req,
  output bfdp_pkg::res_t                   res
);

  // Configuration registers.
  logic                           mode_r;
  logic [bfdp_pkg::CFG_W-1:0]     cap_r;

  // Queue state.
  logic [bfdp_pkg::PTR_W-1:0]     rp_r, rp_nxt;
  logic [bfdp_pkg::PTR_W-1:0]     wp_r, wp_nxt;
  logic [bfdp_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [bfdp_pkg::CNT_W-1:0]     hw_r, hw_nxt;
  logic [bfdp_pkg::TOT_W-1:0]     drops_r, drops_nxt;
  logic [bfdp_pkg::TOT_W-1:0]     recv_r, recv_nxt;
  logic [bfdp_pkg::TOT_W-1:0]     rel_r, rel_nxt;

  // Result flags.
  logic                           valid_r;
  logic [1:0]                     status_r, status_nxt;
  logic                           pop_ok_r, pop_ok_nxt;

  logic [31:0]                    live_cap;
  logic                           full;
  logic [bfdp_pkg::PTR_W-1:0]     rp_inc, wp_inc;

  // Capacity out of range is clamped to one entry or the storage depth.
  always_comb begin
    if (cap_r == '0) begin
      live_cap = 32'd1;
    end else if (32'(cap_r) > 32'(bfdp_pkg::DEPTH)) begin
      live_cap = 32'(bfdp_pkg::DEPTH);
    end else begin
      live_cap = 32'(cap_r);
    end
  end

  assign full = (32'(cnt_r) >= live_cap);

  // Pointers wrap at the storage depth.
  assign rp_inc = (32'(rp_r) == 32'(bfdp_pkg::DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign wp_inc = (32'(wp_r) == 32'(bfdp_pkg::DEPTH - 1)) ? '0 : wp_r + 1'b1;

  // Next state of the queue for the accepted item.
  always_comb begin
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    hw_nxt     = hw_r;
    drops_nxt  = drops_r;
    recv_nxt   = recv_r;
    rel_nxt    = rel_r;
    status_nxt = bfdp_pkg::ST_OK;
    pop_ok_nxt = 1'b0;
    ram_req    = '0;
    ram_req.waddr = wp_r;
    ram_req.wdata = record;
    ram_req.raddr = rp_r;
    if (accept) begin
      if (opcode == bfdp_pkg::OP_PUSH) begin
        if (full) begin
          if (mode_r && (cnt_r != '0)) begin
            // Discard the oldest record, then append; occupancy is unchanged.
            rp_nxt     = rp_inc;
            wp_nxt     = wp_inc;
            drops_nxt  = drops_r + 1'b1;
            rel_nxt    = rel_r + 1'b1;
            recv_nxt   = recv_r + 1'b1;
            ram_req.we = 1'b1;
            status_nxt = bfdp_pkg::ST_DROPPED;
            if (cnt_r > hw_r) begin
              hw_nxt = cnt_r;
            end
          end else begin
            status_nxt = bfdp_pkg::ST_REFUSED;
          end
        end else begin
          // Plain append.
          wp_nxt     = wp_inc;
          cnt_nxt    = cnt_r + 1'b1;
          recv_nxt   = recv_r + 1'b1;
          ram_req.we = 1'b1;
          if (cnt_nxt > hw_r) begin
            hw_nxt = cnt_nxt;
          end
        end
      end else begin
        if (cnt_r == '0) begin
          status_nxt = bfdp_pkg::ST_EMPTY;
        end else begin
          // Read the oldest record; the data comes back with the strobe.
          ram_req.re = 1'b1;
          pop_ok_nxt = 1'b1;
          rp_nxt     = rp_inc;
          cnt_nxt    = cnt_r - 1'b1;
          rel_nxt    = rel_r + 1'b1;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cap_r  <= bfdp_pkg::CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bfdp_pkg::CFG_MODE:     mode_r <= cfg_wdata[0];
        bfdp_pkg::CFG_CAPACITY: cap_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Queue state and statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r    <= '0;
      wp_r    <= '0;
      cnt_r   <= '0;
      hw_r    <= '0;
      drops_r <= '0;
      recv_r  <= '0;
      rel_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      hw_r    <= hw_nxt;
      drops_r <= drops_nxt;
      recv_r  <= recv_nxt;
      rel_r   <= rel_nxt;
      valid_r <= accept;
    end
  end

  // Result flags need no reset; the strobe qualifies them.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pop_ok_r <= pop_ok_nxt;
  end

  // The state registers already hold the values after the item.
  assign res.valid     = valid_r;
  assign res.status    = status_r;
  assign res.pop_ok    = pop_ok_r;
  assign res.occupancy = bfdp_pkg::OCC_W'(cnt_r);
  assign res.dropped   = drops_r;
  assign res.received  = recv_r;
  assign res.released  = rel_r;
  assign res.peak      = bfdp_pkg::OCC_W'(hw_r);

`ifndef ASSERT_OFF
  // Occupancy never goes past the storage depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(bfdp_pkg::DEPTH))
    else $error("occupancy exceeds storage depth");

  // The high-water mark covers the current occupancy.
  a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r >= cnt_r)
    else $error("high-water mark below occupancy");

  // Every accepted item gives a result in the next cycle.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> valid_r)
    else $error("missing result strobe");

  // A pop that finds records leaves one fewer.
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (opcode == bfdp_pkg::OP_POP) && (cnt_r != '0)) |=>
    (cnt_r == bfdp_pkg::CNT_W'($past(cnt_r) - 1'b1)))
    else $error("pop did not decrement occupancy");

  // The memory is never written and read for the same item.
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("record memory read and written together");
`endif

endmodule

### tb/tb_bounded_fifo_with_drop_policy_top.sv
// ----------------------------------------------------------------------------
// tb_bounded_fifo_with_drop_policy_top
// Self-checking testbench for the bounded sensor-record FIFO with drop policy.
// A short table of directed items and register writes exercises the empty,
// full, refused, drop-oldest and out-of-range capacity cases. Random phases
// follow, each with its own mode, capacity and push/pop mix. A local model of
// the queue and its statistics predicts every result not typed in the table;
// every expectation is compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_with_drop_policy_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 870;
  localparam int QUIET_FROM  = 770;
  localparam int SETTLE      = 4;

  // One result item of the block.
  typedef struct packed {
    logic [1:0]                   status;
    logic [bfdp_pkg::VALUE_W-1:0] value;
    logic [bfdp_pkg::ID_W-1:0]    id;
    logic [bfdp_pkg::OCC_W-1:0]   occ;
    logic [bfdp_pkg::TOT_W-1:0]   dropped;
    logic [bfdp_pkg::TOT_W-1:0]   received;
    logic [bfdp_pkg::TOT_W-1:0]   released;
    logic [bfdp_pkg::OCC_W-1:0]   peak;
  } fifo_result_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table: an item or a register write.
  typedef struct packed {
    row_kind_t                    kind;
    bit                           typed;
    logic                         op;
    logic [bfdp_pkg::VALUE_W-1:0] value;
    logic [bfdp_pkg::ID_W-1:0]    id;
    logic [bfdp_pkg::CFGI_W-1:0]  cfg_idx;
    logic [bfdp_pkg::CFG_W-1:0]   cfg_data;
    fifo_result_t                 res;
  } stim_row_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic                                in_opcode = bfdp_pkg::OP_PUSH;
  logic signed [bfdp_pkg::VALUE_W-1:0] in_sensor_value = '0;
  logic [bfdp_pkg::ID_W-1:0]           in_sensor_id = '0;
  logic                                out_valid;
  logic [1:0]                          out_status;
  logic signed [bfdp_pkg::VALUE_W-1:0] out_value;
  logic [bfdp_pkg::ID_W-1:0]           out_id;
  logic [bfdp_pkg::OCC_W-1:0]          out_occupancy;
  logic [bfdp_pkg::TOT_W-1:0]          out_dropped_count;
  logic [bfdp_pkg::TOT_W-1:0]          out_received_count;
  logic [bfdp_pkg::TOT_W-1:0]          out_released_count;
  logic [bfdp_pkg::OCC_W-1:0]          out_peak_occupancy;
  logic                                cfg_we = 1'b0;
  logic [bfdp_pkg::CFGI_W-1:0]         cfg_index = '0;
  logic [bfdp_pkg::CFG_W-1:0]          cfg_wdata = '0;

  // Typed expectation that travels with the item being offered.
  bit                                  typed_flag = 1'b0;
  fifo_result_t                        typed_res = '0;

  // Local copy of the queue, its statistics and its registers.
  logic [bfdp_pkg::VALUE_W-1:0]        model_value [bfdp_pkg::DEPTH];
  logic [bfdp_pkg::ID_W-1:0]           model_id [bfdp_pkg::DEPTH];
  logic [bfdp_pkg::PTR_W-1:0]          model_rd = '0;
  logic [bfdp_pkg::PTR_W-1:0]          model_wr = '0;
  logic [bfdp_pkg::CNT_W-1:0]          model_count = '0;
  logic [bfdp_pkg::TOT_W-1:0]          model_drops = '0;
  logic [bfdp_pkg::TOT_W-1:0]          model_accepted = '0;
  logic [bfdp_pkg::TOT_W-1:0]          model_removed = '0;
  logic [bfdp_pkg::OCC_W-1:0]          model_peak = '0;
  bit                                  shadow_drop_oldest = 1'b0;
  logic [bfdp_pkg::CFG_W-1:0]          shadow_capacity = bfdp_pkg::CAP_RESET;

  fifo_result_t                        pending_results [$];
  stim_row_t                           stim_table [$];
  int                                  errors = 0;
  int                                  item_count = 0;
  bit                                  gaps_on = 1'b1;

  bounded_fifo_with_drop_policy_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_sensor_value    (in_sensor_value),
    .in_sensor_id       (in_sensor_id),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_value          (out_value),
    .out_id             (out_id),
    .out_occupancy      (out_occupancy),
    .out_dropped_count  (out_dropped_count),
    .out_received_count (out_received_count),
    .out_released_count (out_released_count),
    .out_peak_occupancy (out_peak_occupancy),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pointers wrap at the storage depth.
  function automatic logic [bfdp_pkg::PTR_W-1:0] next_slot(logic [bfdp_pkg::PTR_W-1:0] p);
    return (32'(p) == 32'(bfdp_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Drop the oldest record and count it as released.
  function automatic void retire_oldest();
    model_rd = next_slot(model_rd);
    model_count--;
    model_removed++;
  endfunction

  // Append a record and track the high-water mark.
  function automatic void store_record(logic [bfdp_pkg::VALUE_W-1:0] value,
                                       logic [bfdp_pkg::ID_W-1:0] id);
    model_value[model_wr] = value;
    model_id[model_wr] = id;
    model_wr = next_slot(model_wr);
    model_count++;
    model_accepted++;
    if (bfdp_pkg::OCC_W'(model_count) > model_peak) begin
      model_peak = bfdp_pkg::OCC_W'(model_count);
    end
  endfunction

  // Apply one item to the local queue and return the result it produces.
  function automatic fifo_result_t predict_fifo_result(logic op,
                                                      logic [bfdp_pkg::VALUE_W-1:0] value,
                                                      logic [bfdp_pkg::ID_W-1:0] id);
    fifo_result_t r;
    int           live_cap;
    r = '0;
    r.status = bfdp_pkg::ST_OK;
    // A capacity of zero behaves as one, anything above the depth as the depth.
    if (shadow_capacity == '0) begin
      live_cap = 1;
    end else if (int'(shadow_capacity) > bfdp_pkg::DEPTH) begin
      live_cap = bfdp_pkg::DEPTH;
    end else begin
      live_cap = int'(shadow_capacity);
    end
    if (op == bfdp_pkg::OP_PUSH) begin
      if (int'(model_count) >= live_cap) begin
        if (shadow_drop_oldest && model_count != '0) begin
          retire_oldest();
          model_drops++;
          store_record(value, id);
          r.status = bfdp_pkg::ST_DROPPED;
        end else begin
          r.status = bfdp_pkg::ST_REFUSED;
        end
      end else begin
        store_record(value, id);
      end
    end else begin
      if (model_count == '0) begin
        r.status = bfdp_pkg::ST_EMPTY;
      end else begin
        r.value = model_value[model_rd];
        r.id = model_id[model_rd];
        retire_oldest();
      end
    end
    r.occ = bfdp_pkg::OCC_W'(model_count);
    r.dropped = model_drops;
    r.received = model_accepted;
    r.released = model_removed;
    r.peak = model_peak;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Record every accepted item, then check any result shown this cycle.
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    fifo_result_t got;
    if (rst_n && start && !busy) begin
      want = predict_fifo_result(in_opcode, in_sensor_value, in_sensor_id);
      pending_results.push_back(typed_flag ? typed_res : want);
    end
    if (rst_n && out_valid) begin
      got = {out_status, out_value, out_id, out_occupancy, out_dropped_count,
             out_received_count, out_released_count, out_peak_occupancy};
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("value", want.value, got.value);
        check_field("id", 32'(want.id), 32'(got.id));
        check_field("occupancy", 32'(want.occ), 32'(got.occ));
        check_field("dropped_count", want.dropped, got.dropped);
        check_field("received_count", want.received, got.received);
        check_field("released_count", want.released, got.released);
        check_field("peak_occupancy", 32'(want.peak), 32'(got.peak));
      end
    end
  end

  // Offer one item, possibly after a short idle burst, and wait until taken.
  task automatic send_item(logic op, logic [bfdp_pkg::VALUE_W-1:0] value,
                           logic [bfdp_pkg::ID_W-1:0] id, bit typed, fifo_result_t res);
    if (gaps_on && item_count < QUIET_FROM && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_sensor_value <= value;
    in_sensor_id <= id;
    typed_flag <= typed;
    typed_res <= res;
    do @(posedge clk); while (busy);
    item_count++;
  endtask

  // Register writes happen only once every outstanding result has come back.
  task automatic cfg_write(logic [bfdp_pkg::CFGI_W-1:0] idx,
                           logic [bfdp_pkg::CFG_W-1:0] data);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bfdp_pkg::CFG_MODE) begin
      shadow_drop_oldest = data[0];
    end else begin
      shadow_capacity = data;
    end
  endtask

  function automatic stim_row_t item_row(logic op, logic [bfdp_pkg::VALUE_W-1:0] value,
                                         logic [bfdp_pkg::ID_W-1:0] id);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.value = value;
    row.id = id;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic op, logic [bfdp_pkg::VALUE_W-1:0] value,
                                          logic [bfdp_pkg::ID_W-1:0] id, fifo_result_t res);
    stim_row_t row;
    row = item_row(op, value, id);
    row.typed = 1'b1;
    row.res = res;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [bfdp_pkg::CFGI_W-1:0] idx,
                                        logic [bfdp_pkg::CFG_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_data = data;
    return row;
  endfunction

  // Directed table, then random phases, then drain and report.
  initial begin : stimulus
    int                         phase;
    int                         phase_len;
    int                         push_pct;
    int                         n;
    bit                         mode;
    logic [bfdp_pkg::CFG_W-1:0] cap;
    logic                       op;

    // Typed results are in field order: status, value, id, occupancy,
    // dropped, received, released, peak.
    // Empty queue after reset, then extremes of value and id.
    stim_table.push_back(typed_row(bfdp_pkg::OP_POP, 32'h0, 16'h0,
      '{bfdp_pkg::ST_EMPTY, 32'h0, 16'h0, 7'd0, 32'd0, 32'd0, 32'd0, 7'd0}));
    stim_table.push_back(typed_row(bfdp_pkg::OP_PUSH, 32'h7FFF_FFFF, 16'hFFFF,
      '{bfdp_pkg::ST_OK, 32'h0, 16'h0, 7'd1, 32'd0, 32'd1, 32'd0, 7'd1}));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'h8000_0000, 16'h0000));
    stim_table.push_back(typed_row(bfdp_pkg::OP_POP, 32'h0, 16'h0,
      '{bfdp_pkg::ST_OK, 32'h7FFF_FFFF, 16'hFFFF, 7'd1, 32'd0, 32'd2, 32'd1, 7'd2}));
    // Pop fields carry junk that must be ignored.
    stim_table.push_back(item_row(bfdp_pkg::OP_POP, 32'hFFFF_FFFF, 16'hFFFF));
    stim_table.push_back(typed_row(bfdp_pkg::OP_POP, 32'h0, 16'h0,
      '{bfdp_pkg::ST_EMPTY, 32'h0, 16'h0, 7'd0, 32'd0, 32'd2, 32'd2, 7'd2}));
    // Smallest capacity: refused when full, then dropping the oldest.
    stim_table.push_back(cfg_row(bfdp_pkg::CFG_CAPACITY, 7'd1));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'd1234, 16'd1));
    stim_table.push_back(typed_row(bfdp_pkg::OP_PUSH, 32'd5, 16'd2,
      '{bfdp_pkg::ST_REFUSED, 32'h0, 16'h0, 7'd1, 32'd0, 32'd3, 32'd2, 7'd2}));
    stim_table.push_back(cfg_row(bfdp_pkg::CFG_MODE, 7'd1));
    stim_table.push_back(typed_row(bfdp_pkg::OP_PUSH, 32'd6, 16'd3,
      '{bfdp_pkg::ST_DROPPED, 32'h0, 16'h0, 7'd1, 32'd1, 32'd4, 32'd3, 7'd2}));
    stim_table.push_back(item_row(bfdp_pkg::OP_POP, 32'h0, 16'h0));
    // A capacity of zero acts as one.
    stim_table.push_back(cfg_row(bfdp_pkg::CFG_CAPACITY, 7'd0));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'hFFFF_FFFF, 16'd4));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'h0, 16'd5));
    // A capacity above the depth acts as the depth.
    stim_table.push_back(cfg_row(bfdp_pkg::CFG_CAPACITY, 7'd127));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'd7, 16'd6));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'd8, 16'd7));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'd9, 16'd8));
    // Capacity lowered below occupancy: drop keeps occupancy, refuse changes nothing.
    stim_table.push_back(cfg_row(bfdp_pkg::CFG_CAPACITY, 7'd2));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'hA5A5_5A5A, 16'd9));
    stim_table.push_back(cfg_row(bfdp_pkg::CFG_MODE, 7'd0));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'h5A5A_A5A5, 16'd10));
    stim_table.push_back(item_row(bfdp_pkg::OP_POP, 32'h0, 16'h0));
    stim_table.push_back(item_row(bfdp_pkg::OP_POP, 32'h0, 16'h0));
    stim_table.push_back(item_row(bfdp_pkg::OP_POP, 32'h0, 16'h0));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'd11, 16'd11));
    stim_table.push_back(item_row(bfdp_pkg::OP_PUSH, 32'd12, 16'd12));
    stim_table.push_back(item_row(bfdp_pkg::OP_POP, 32'h0, 16'h0));

    // Synchronous reset held low, then released.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        cfg_write(stim_table[i].cfg_idx, stim_table[i].cfg_data);
      end else begin
        send_item(stim_table[i].op, stim_table[i].value, stim_table[i].id,
                  stim_table[i].typed, stim_table[i].res);
      end
    end

    // Random phases. The first two fill the full-depth queue in both modes;
    // the rest pick mode, capacity and mix at random.
    phase = 0;
    while (item_count < TOTAL_ITEMS) begin
      if (phase == 0) begin
        mode = 1'b1;
        cap = 7'd64;
        push_pct = 90;
        phase_len = 110;
      end else if (phase == 1) begin
        mode = 1'b0;
        cap = 7'd64;
        push_pct = 85;
        phase_len = 60;
      end else begin
        mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 6))
          0: cap = 7'd0;
          1: cap = 7'd1;
          2: cap = 7'd2;
          3: cap = 7'd64;
          4: cap = 7'd127;
          default: cap = 7'($urandom_range(3, 63));
        endcase
        push_pct = $urandom_range(15, 90);
        phase_len = $urandom_range(40, 110);
      end
      // Upper bits of the mode write are junk and must be masked off.
      cfg_write(bfdp_pkg::CFG_MODE, {6'($urandom_range(0, 63)), mode});
      cfg_write(bfdp_pkg::CFG_CAPACITY, cap);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (n = 0; n < phase_len && item_count < TOTAL_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < push_pct) ? bfdp_pkg::OP_PUSH : bfdp_pkg::OP_POP;
        send_item(op, $urandom, 16'($urandom_range(0, 65535)), 1'b0, '0);
      end
      phase++;
    end

    // Drain: wait for the last results, bounded.
    start <= 1'b0;
    for (n = 0; n < 100 && pending_results.size() != 0; n++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: results missing, expected 0 outstanding, actual %0d", $time,
               pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
